### sv/mtc_pkg.sv
`timescale 1ns / 1ps

package mtc_pkg;

	// request kinds carried on the input tuser
	typedef enum logic [1:0] {
		REQ_QUARTER = 2'd0,
		REQ_FULL    = 2'd1,
		REQ_TICK    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	localparam int unsigned IN_DATA_W  = 40;
	localparam int unsigned OUT_DATA_W = 32;

	localparam logic [2:0] LAST_PART = 3'd7;
	localparam logic [6:0] SEC_MIN_WRAP = 7'd60;
	localparam logic [6:0] SEC_MIN_MAX  = 7'd59;
	localparam logic [4:0] HOURS_WRAP   = 5'd24;
	localparam logic [4:0] HOURS_MAX    = 5'd23;
	localparam logic [5:0] TICK_MAX     = 6'd63;
	localparam logic [6:0] GAP_CLAMP    = 7'd2;

	// one result beat
	typedef struct packed {
		logic       restart_timer;
		logic       send_update;
		logic [1:0] tc_rate;
		logic [6:0] tc_frames;
		logic [6:0] tc_seconds;
		logic [6:0] tc_minutes;
		logic [4:0] tc_hours;
	} result_t;

	// frames per second of each rate type
	function automatic logic [6:0] fps_of_rate(input logic [1:0] rate);
		logic [6:0] fps;
		case (rate)
			2'd0: fps = 7'd24;
			2'd1: fps = 7'd25;
			default: fps = 7'd30;
		endcase
		return fps;
	endfunction

endpackage

### sv/mtc_timecode_tracker_unit.sv
`timescale 1ns / 1ps

// midi time code tracker
// input channel s_axis: tuser carries the request kind (quarter frame, full
// frame message, frame timer tick), tdata the quarter-frame byte and the
// full-frame time bytes. output channel m_axis: one beat with the current
// time, rate type and the send_update / restart_timer flags, for every full
// frame, every tick and every quarter frame that closes a set of eight.
// other quarter frames and unused request kinds give no beat.
// a beat is taken into the input register and then into the result register,
// from which it shows on m_axis.
// throughput: one beat per cycle while m_axis does not stall; all time arithmetic
// is done in one pass between the input register and the result register.
// reset: arst_n clears the time, the nibble slots, the gap and tick count,
// and sets the running direction to forward; both channels go empty.
// a stall on m_axis holds the result register; the input register keeps
// taking beats that need no result, and backs up one beat otherwise.
module mtc_timecode_tracker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// qf_byte, full_rate_hours, full_minutes, full_seconds, full_frames, zero pad
	input  logic [39:0] s_axis_tdata,
	// req_type
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tc_hours, tc_minutes, tc_seconds, tc_frames, tc_rate, send_update,
	// restart_timer, zero pad
	output logic [31:0] m_axis_tdata
);

	// input register
	logic        valid_s1;
	logic [1:0]  req_s1;
	logic [34:0] data_s1;

	// tracker state
	logic [3:0] slots_q [8];
	logic [2:0] last_part_q;
	logic       forward_q;
	logic [6:0] last_frame_q;
	logic [6:0] gap_q;
	logic [5:0] tick_q;
	logic [4:0] hours_q;
	logic [6:0] minutes_q;
	logic [6:0] seconds_q;
	logic [6:0] frames_q;
	logic [1:0] rate_q;

	// result register
	logic            out_valid_q;
	mtc_pkg::result_t out_q;

	// next state and result
	logic [3:0] slots_d [8];
	logic [2:0] last_part_d;
	logic       forward_d;
	logic [6:0] last_frame_d;
	logic [6:0] gap_d;
	logic [5:0] tick_d;
	logic [4:0] hours_d;
	logic [6:0] minutes_d;
	logic [6:0] seconds_d;
	logic [6:0] frames_d;
	logic [1:0] rate_d;
	logic       has_result;
	logic       send_d;
	logic       restart_d;

	logic out_free;
	logic advance;

	// quarter frame decode
	logic [2:0] part;
	logic [3:0] nibble;
	logic       closing;
	logic [6:0] asm_frames;
	logic [6:0] asm_fps;
	logic [6:0] gap_raw;
	logic [1:0] asm_rate;

	// tick stepping
	logic [6:0] fps_cur;
	logic [6:0] fw_frames, fw_seconds, fw_minutes;
	logic [4:0] fw_hours;
	logic       fw_c_f, fw_c_s, fw_c_m;
	logic [6:0] bw_frames, bw_seconds, bw_minutes;
	logic [4:0] bw_hours;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (out_free || !has_result);
	assign s_axis_tready = !valid_s1 || advance;

	// input register load
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			req_s1  <= s_axis_tuser;
			data_s1 <= s_axis_tdata[34:0];
		end
	end

	assign part   = data_s1[6:4];
	assign nibble = data_s1[3:0];

	// forward step with carry
	always_comb begin
		fw_frames  = frames_q + 7'd1;
		fw_c_f     = !(fw_frames < fps_cur && fw_frames != 7'd0);
		fw_seconds = seconds_q;
		fw_minutes = minutes_q;
		fw_hours   = hours_q;
		fw_c_s     = 1'b0;
		fw_c_m     = 1'b0;
		if (fw_c_f) begin
			fw_frames  = 7'd0;
			fw_seconds = seconds_q + 7'd1;
			fw_c_s     = !(fw_seconds < mtc_pkg::SEC_MIN_WRAP && fw_seconds != 7'd0);
		end
		if (fw_c_s) begin
			fw_seconds = 7'd0;
			fw_minutes = minutes_q + 7'd1;
			fw_c_m     = !(fw_minutes < mtc_pkg::SEC_MIN_WRAP && fw_minutes != 7'd0);
		end
		if (fw_c_m) begin
			fw_minutes = 7'd0;
			fw_hours   = hours_q + 5'd1;
			if (fw_hours >= mtc_pkg::HOURS_WRAP) begin
				fw_hours = 5'd0;
			end
		end
	end

	// backward step with borrow
	always_comb begin
		bw_frames  = frames_q;
		bw_seconds = seconds_q;
		bw_minutes = minutes_q;
		bw_hours   = hours_q;
		if (frames_q != 7'd0) begin
			bw_frames = frames_q - 7'd1;
		end else begin
			bw_frames = fps_cur - 7'd1;
			if (seconds_q != 7'd0) begin
				bw_seconds = seconds_q - 7'd1;
			end else begin
				bw_seconds = mtc_pkg::SEC_MIN_MAX;
				if (minutes_q != 7'd0) begin
					bw_minutes = minutes_q - 7'd1;
				end else begin
					bw_minutes = mtc_pkg::SEC_MIN_MAX;
					bw_hours   = (hours_q != 5'd0) ? hours_q - 5'd1 : mtc_pkg::HOURS_MAX;
				end
			end
		end
	end

	assign fps_cur = mtc_pkg::fps_of_rate(rate_q);

	// per-request next state
	always_comb begin
		slots_d      = slots_q;
		last_part_d  = last_part_q;
		forward_d    = forward_q;
		last_frame_d = last_frame_q;
		gap_d        = gap_q;
		tick_d       = tick_q;
		hours_d      = hours_q;
		minutes_d    = minutes_q;
		seconds_d    = seconds_q;
		frames_d     = frames_q;
		rate_d       = rate_q;
		has_result   = 1'b0;
		send_d       = 1'b0;
		restart_d    = 1'b0;
		closing      = 1'b0;
		asm_frames   = 7'd0;
		asm_rate     = 2'd0;
		asm_fps      = 7'd0;
		gap_raw      = 7'd0;
		case (mtc_pkg::req_t'(req_s1))
			mtc_pkg::REQ_QUARTER: begin
				slots_d[part] = nibble;
				if (part != mtc_pkg::LAST_PART && last_part_q != mtc_pkg::LAST_PART) begin
					forward_d = (last_part_q < part);
				end
				closing = (forward_d && part == mtc_pkg::LAST_PART) ||
					(!forward_d && part == 3'd0);
				last_part_d = part;
				if (closing) begin
					asm_frames = {slots_d[1][2:0], slots_d[0]};
					asm_rate   = slots_d[7][2:1];
					asm_fps    = mtc_pkg::fps_of_rate(asm_rate);
					gap_raw    = (asm_frames < last_frame_q) ? last_frame_q - asm_frames
						: asm_frames - last_frame_q;
					frames_d     = asm_frames;
					seconds_d    = {slots_d[3][2:0], slots_d[2]};
					minutes_d    = {slots_d[5][2:0], slots_d[4]};
					hours_d      = {slots_d[7][0], slots_d[6]};
					rate_d       = asm_rate;
					last_frame_d = asm_frames;
					gap_d        = (gap_raw >= asm_fps - 7'd2) ? mtc_pkg::GAP_CLAMP : gap_raw;
					send_d       = ({1'b0, tick_q} < gap_d);
					restart_d    = 1'b1;
					tick_d       = 6'd0;
					has_result   = 1'b1;
				end
			end
			mtc_pkg::REQ_FULL: begin
				hours_d    = data_s1[11:7];
				rate_d     = data_s1[13:12];
				minutes_d  = data_s1[20:14];
				seconds_d  = data_s1[27:21];
				frames_d   = data_s1[34:28];
				tick_d     = 6'd0;
				send_d     = 1'b1;
				has_result = 1'b1;
			end
			mtc_pkg::REQ_TICK: begin
				if (tick_q < mtc_pkg::TICK_MAX) begin
					tick_d = tick_q + 6'd1;
				end
				if (forward_q) begin
					frames_d  = fw_frames;
					seconds_d = fw_seconds;
					minutes_d = fw_minutes;
					hours_d   = fw_hours;
				end else begin
					frames_d  = bw_frames;
					seconds_d = bw_seconds;
					minutes_d = bw_minutes;
					hours_d   = bw_hours;
				end
				if (gap_q == mtc_pkg::GAP_CLAMP) begin
					gap_d     = 7'd0;
					restart_d = 1'b1;
				end
				send_d     = 1'b1;
				has_result = 1'b1;
			end
			default: begin
				has_result = 1'b0;
			end
		endcase
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++) begin
				slots_q[i] <= 4'd0;
			end
			last_part_q  <= 3'd0;
			forward_q    <= 1'b1;
			last_frame_q <= 7'd0;
			gap_q        <= 7'd0;
			tick_q       <= 6'd0;
			hours_q      <= 5'd0;
			minutes_q    <= 7'd0;
			seconds_q    <= 7'd0;
			frames_q     <= 7'd0;
			rate_q       <= 2'd0;
		end else if (advance) begin
			slots_q      <= slots_d;
			last_part_q  <= last_part_d;
			forward_q    <= forward_d;
			last_frame_q <= last_frame_d;
			gap_q        <= gap_d;
			tick_q       <= tick_d;
			hours_q      <= hours_d;
			minutes_q    <= minutes_d;
			seconds_q    <= seconds_d;
			frames_q     <= frames_d;
			rate_q       <= rate_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && has_result;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && advance && has_result) begin
			out_q.tc_hours      <= hours_d;
			out_q.tc_minutes    <= minutes_d;
			out_q.tc_seconds    <= seconds_d;
			out_q.tc_frames     <= frames_d;
			out_q.tc_rate       <= rate_d;
			out_q.send_update   <= send_d;
			out_q.restart_timer <= restart_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_q};

endmodule

### tb/mtc_timecode_tracker_unit_test.sv
`timescale 1ns / 1ps

module mtc_timecode_tracker_unit_test;

	localparam int unsigned ITEM_TARGET    = 550;
	localparam int unsigned WATCHDOG_LIMIT = 2000;
	localparam int unsigned RX_HOLD_CYCLES = 60;
	localparam int unsigned END_SETTLE     = 8;
	localparam int unsigned MAX_REPORTS    = 10;

	localparam logic [2:0] FIRST_PART   = 3'd0;
	localparam logic [2:0] FINAL_PART   = 3'd7;
	localparam logic [5:0] TICK_CEILING = 6'd63;
	localparam logic [6:0] GAP_SNAP     = 7'd2;
	localparam logic [6:0] WRAP_SIXTY   = 7'd60;
	localparam logic [6:0] MAX_SIXTY    = 7'd59;
	localparam logic [4:0] WRAP_DAY     = 5'd24;
	localparam logic [4:0] MAX_HOUR     = 5'd23;
	localparam logic [6:0] FPS_TABLE [4] = '{7'd24, 7'd25, 7'd30, 7'd30};

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_axis_tvalid = 1'b0;
	logic                           s_axis_tready;
	logic [mtc_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [1:0]                     s_axis_tuser = mtc_pkg::REQ_NONE;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready = 1'b0;
	logic [mtc_pkg::OUT_DATA_W-1:0] m_axis_tdata;

	// predicted tracker state
	logic [3:0] slot_nibbles [8];
	logic [2:0] prev_part;
	logic       runs_forward;
	logic [6:0] seen_frame;
	logic [6:0] gap_frames;
	logic [5:0] ticks_since;
	logic [4:0] cur_hours;
	logic [6:0] cur_minutes;
	logic [6:0] cur_seconds;
	logic [6:0] cur_frames;
	logic [1:0] cur_rate;

	mtc_pkg::result_t timecode_due [$];
	int unsigned beats_sent = 0;
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	int unsigned hold_requests = 0;
	int unsigned hold_served = 0;
	int unsigned rx_stall_left = 0;
	logic        no_idle = 1'b0;

	mtc_timecode_tracker_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// random pause length: mostly none or short, a few long
	function automatic int unsigned idle_span();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_idle)
			return 0;
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [mtc_pkg::IN_DATA_W-1:0] random_fill();
		return {5'd0, 3'($urandom), 32'($urandom)};
	endfunction

	function automatic logic [mtc_pkg::IN_DATA_W-1:0] qf_payload(input logic [2:0] part,
		input logic [3:0] nibble);
		logic [mtc_pkg::IN_DATA_W-1:0] r;
		r = random_fill();
		r[6:0] = {part, nibble};
		return r;
	endfunction

	function automatic logic [mtc_pkg::IN_DATA_W-1:0] full_payload(input logic [1:0] rate,
		input logic [4:0] hours, input logic [6:0] minutes, input logic [6:0] seconds,
		input logic [6:0] frames);
		logic [mtc_pkg::IN_DATA_W-1:0] r;
		r = random_fill();
		r[34:7] = {frames, seconds, minutes, rate, hours};
		return r;
	endfunction

	// eight quarter-frame nibbles, slot 0 in the lowest bits
	function automatic logic [31:0] slot_word(input logic [1:0] rate, input logic [4:0] hours,
		input logic [6:0] minutes, input logic [6:0] seconds, input logic [6:0] frames);
		return {1'b0, rate, hours[4], hours[3:0], 1'b0, minutes[6:4], minutes[3:0],
			1'b0, seconds[6:4], seconds[3:0], 1'b0, frames[6:4], frames[3:0]};
	endfunction

	function automatic void queue_timecode(input logic send, input logic restart);
		mtc_pkg::result_t r;
		r.tc_hours      = cur_hours;
		r.tc_minutes    = cur_minutes;
		r.tc_seconds    = cur_seconds;
		r.tc_frames     = cur_frames;
		r.tc_rate       = cur_rate;
		r.send_update   = send;
		r.restart_timer = restart;
		timecode_due.push_back(r);
	endfunction

	// one frame forward with carry
	function automatic void advance_frame(input logic [6:0] fps);
		cur_frames = cur_frames + 7'd1;
		if (cur_frames < fps && cur_frames != 7'd0)
			return;
		cur_frames  = 7'd0;
		cur_seconds = cur_seconds + 7'd1;
		if (cur_seconds < WRAP_SIXTY && cur_seconds != 7'd0)
			return;
		cur_seconds = 7'd0;
		cur_minutes = cur_minutes + 7'd1;
		if (cur_minutes < WRAP_SIXTY && cur_minutes != 7'd0)
			return;
		cur_minutes = 7'd0;
		cur_hours   = cur_hours + 5'd1;
		if (cur_hours >= WRAP_DAY)
			cur_hours = 5'd0;
	endfunction

	// one frame backward with borrow
	function automatic void rewind_frame(input logic [6:0] fps);
		if (cur_frames != 7'd0) begin
			cur_frames = cur_frames - 7'd1;
			return;
		end
		cur_frames = fps - 7'd1;
		if (cur_seconds != 7'd0) begin
			cur_seconds = cur_seconds - 7'd1;
			return;
		end
		cur_seconds = MAX_SIXTY;
		if (cur_minutes != 7'd0) begin
			cur_minutes = cur_minutes - 7'd1;
			return;
		end
		cur_minutes = MAX_SIXTY;
		if (cur_hours != 5'd0)
			cur_hours = cur_hours - 5'd1;
		else
			cur_hours = MAX_HOUR;
	endfunction

	function automatic void clear_tracker();
		foreach (slot_nibbles[i])
			slot_nibbles[i] = 4'd0;
		prev_part    = FIRST_PART;
		runs_forward = 1'b1;
		seen_frame   = 7'd0;
		gap_frames   = 7'd0;
		ticks_since  = 6'd0;
		cur_hours    = 5'd0;
		cur_minutes  = 7'd0;
		cur_seconds  = 7'd0;
		cur_frames   = 7'd0;
		cur_rate     = 2'd0;
	endfunction

	// predicted effect of one accepted beat
	function automatic void follow_timecode(input mtc_pkg::req_t kind,
		input logic [mtc_pkg::IN_DATA_W-1:0] payload);
		logic [2:0] part;
		logic [6:0] fps;
		logic [6:0] gap;
		logic       closing;
		logic       restart;
		case (kind)
			mtc_pkg::REQ_QUARTER: begin
				part = payload[6:4];
				slot_nibbles[part] = payload[3:0];
				if (part != FINAL_PART && prev_part != FINAL_PART)
					runs_forward = (prev_part < part);
				closing = runs_forward ? (part == FINAL_PART) : (part == FIRST_PART);
				prev_part = part;
				if (closing) begin
					cur_frames  = {slot_nibbles[1][2:0], slot_nibbles[0]};
					cur_seconds = {slot_nibbles[3][2:0], slot_nibbles[2]};
					cur_minutes = {slot_nibbles[5][2:0], slot_nibbles[4]};
					cur_hours   = {slot_nibbles[7][0], slot_nibbles[6]};
					cur_rate    = slot_nibbles[7][2:1];
					fps = FPS_TABLE[cur_rate];
					gap = (cur_frames < seen_frame) ? seen_frame - cur_frames
						: cur_frames - seen_frame;
					seen_frame = cur_frames;
					if (gap >= fps - 7'd2)
						gap = GAP_SNAP;
					gap_frames = gap;
					queue_timecode(ticks_since < gap_frames, 1'b1);
					ticks_since = 6'd0;
				end
			end
			mtc_pkg::REQ_FULL: begin
				cur_hours   = payload[11:7];
				cur_rate    = payload[13:12];
				cur_minutes = payload[20:14];
				cur_seconds = payload[27:21];
				cur_frames  = payload[34:28];
				ticks_since = 6'd0;
				queue_timecode(1'b1, 1'b0);
			end
			mtc_pkg::REQ_TICK: begin
				fps = FPS_TABLE[cur_rate];
				if (ticks_since != TICK_CEILING)
					ticks_since = ticks_since + 6'd1;
				if (runs_forward)
					advance_frame(fps);
				else
					rewind_frame(fps);
				restart = (gap_frames == GAP_SNAP);
				if (restart)
					gap_frames = 7'd0;
				queue_timecode(1'b1, restart);
			end
			default: begin
			end
		endcase
	endfunction

	// offer one beat after a random pause and wait for it to be taken
	task automatic send_beat(input mtc_pkg::req_t kind,
		input logic [mtc_pkg::IN_DATA_W-1:0] payload);
		int unsigned pause;
		pause = idle_span();
		if (pause != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= kind;
		s_axis_tdata  <= payload;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		follow_timecode(kind, payload);
		if (kind != mtc_pkg::REQ_NONE)
			beats_sent++;
	endtask

	// eight quarter frames in running order
	task automatic send_qf_set(input logic forward, input logic [31:0] slots);
		int p;
		for (int i = 0; i < 8; i++) begin
			p = forward ? i : 7 - i;
			send_beat(mtc_pkg::REQ_QUARTER, qf_payload(3'(p), slots[p*4 +: 4]));
		end
	endtask

	task automatic wait_results_drained();
		s_axis_tvalid <= 1'b0;
		while (timecode_due.size() != 0)
			@(posedge clk);
		repeat (END_SETTLE) @(posedge clk);
	endtask

	task automatic test_full_frame_loads();
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd0, 5'd0, 7'd0, 7'd0, 7'd0));
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd3, 5'd31, 7'd127, 7'd127, 7'd127));
		// every field overflows at once
		send_beat(mtc_pkg::REQ_TICK, random_fill());
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd3, 5'd23, 7'd59, 7'd59, 7'd29));
		send_beat(mtc_pkg::REQ_TICK, random_fill());
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd1, 5'd9, 7'd12, 7'd59, 7'd24));
		send_beat(mtc_pkg::REQ_TICK, random_fill());
	endtask

	task automatic test_quarter_frame_sets();
		logic [31:0] slots;
		// unused high bits of slot 1 and slot 7 set, gap snaps to two
		slots = slot_word(2'd3, 5'd17, 7'd59, 7'd45, 7'd28) | 32'h8000_0080;
		send_qf_set(1'b1, slots);
		send_beat(mtc_pkg::REQ_TICK, random_fill());
		// repeated closing part keeps the direction
		send_beat(mtc_pkg::REQ_QUARTER, qf_payload(FINAL_PART, slots[31:28]));
		send_beat(mtc_pkg::REQ_NONE, random_fill());
		// backward set to zero time, then borrow through every field
		send_qf_set(1'b0, 32'd0);
		send_beat(mtc_pkg::REQ_TICK, random_fill());
		wait_results_drained();
	endtask

	task automatic test_tick_saturation();
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd2, 5'd1, 7'd0, 7'd0, 7'd0));
		no_idle <= 1'b1;
		repeat (66) send_beat(mtc_pkg::REQ_TICK, random_fill());
		no_idle <= 1'b0;
		send_qf_set(1'b1, slot_word(2'd2, 5'd1, 7'd0, 7'd1, 7'd20));
		send_beat(mtc_pkg::REQ_FULL, full_payload(2'd0, 5'd2, 7'd3, 7'd4, 7'd5));
		send_qf_set(1'b1, slot_word(2'd0, 5'd2, 7'd3, 7'd4, 7'd9));
		wait_results_drained();
	endtask

	task automatic test_output_backpressure();
		hold_requests <= hold_requests + 1;
		repeat (24) send_beat(mtc_pkg::REQ_TICK, random_fill());
		wait_results_drained();
	endtask

	task automatic test_random_traffic();
		int unsigned pick;
		int unsigned run;
		logic [1:0]  rate;
		logic [6:0]  src_frame;
		src_frame = 7'd0;
		while (beats_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0)
				no_idle <= ~no_idle;
			pick = $urandom_range(0, 99);
			if (pick < 45) begin
				rate = 2'($urandom_range(0, 3));
				src_frame = 7'(($urandom_range(0, 1) ? src_frame + 2
					: src_frame + $urandom_range(0, 20)) % 24);
				if ($urandom_range(0, 3) == 0)
					send_qf_set(1'($urandom_range(0, 1)), $urandom);
				else
					send_qf_set(1'($urandom_range(0, 1)), slot_word(rate,
						5'($urandom_range(0, 23)), 7'($urandom_range(0, 59)),
						7'($urandom_range(0, 59)), src_frame));
			end else if (pick < 70) begin
				run = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 70)
					: $urandom_range(1, 6);
				repeat (run) send_beat(mtc_pkg::REQ_TICK, random_fill());
			end else if (pick < 80) begin
				send_beat(mtc_pkg::REQ_FULL, random_fill());
			end else if (pick < 88) begin
				// broken sequence of random parts
				run = $urandom_range(1, 5);
				repeat (run) send_beat(mtc_pkg::REQ_QUARTER, random_fill());
			end else if (pick < 96) begin
				send_beat($urandom_range(0, 1) ? mtc_pkg::REQ_NONE : mtc_pkg::REQ_QUARTER,
					random_fill());
			end else begin
				wait_results_drained();
			end
		end
		no_idle <= 1'b0;
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_served != hold_requests) begin
			hold_served   <= hold_requests;
			rx_stall_left <= RX_HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (rx_stall_left != 0) begin
			rx_stall_left <= rx_stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			rx_stall_left <= idle_span();
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// compare each result beat with the oldest predicted time code
	always @(posedge clk) begin
		mtc_pkg::result_t got;
		mtc_pkg::result_t want;
		if (m_axis_tvalid === 1'b1 && m_axis_tready) begin
			got = mtc_pkg::result_t'(m_axis_tdata[29:0]);
			if (timecode_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result beat %h", m_axis_tdata);
			end else begin
				want = timecode_due.pop_front();
				if (got.tc_hours !== want.tc_hours || got.tc_minutes !== want.tc_minutes
					|| got.tc_seconds !== want.tc_seconds || got.tc_frames !== want.tc_frames
					|| got.tc_rate !== want.tc_rate || got.send_update !== want.send_update
					|| got.restart_timer !== want.restart_timer) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("mismatch: expected %0d:%0d:%0d:%0d rate %0d send %b restart %b",
							want.tc_hours, want.tc_minutes, want.tc_seconds, want.tc_frames,
							want.tc_rate, want.send_update, want.restart_timer,
							", got %0d:%0d:%0d:%0d rate %0d send %b restart %b",
							got.tc_hours, got.tc_minutes, got.tc_seconds, got.tc_frames,
							got.tc_rate, got.send_update, got.restart_timer);
				end
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid === 1'b1 && m_axis_tready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		clear_tracker();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_full_frame_loads();
		test_quarter_frame_sets();
		test_tick_saturation();
		test_output_backpressure();
		test_random_traffic();
		wait_results_drained();
		if (mismatches == 0 && timecode_due.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
